// ===== hdl/median_hamming_descriptor_select_core_assert.svh =====
// Assertion macros used by the checker file
`ifndef MEDIAN_HAMMING_DESCRIPTOR_SELECT_CORE_ASSERT_SVH
`define MEDIAN_HAMMING_DESCRIPTOR_SELECT_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MHDS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MHDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/mhds_pkg.sv =====
// Package: constants, types and helpers for the descriptor medoid selector
package mhds_pkg;
    localparam int MaxDesc = 64;
    localparam int IdxW = $clog2(MaxDesc);
    localparam int CntW = $clog2(MaxDesc + 1);
    localparam int DistW = 9;
    localparam int DescW = 256;
    localparam int TabDepth = MaxDesc * MaxDesc;
    localparam int TabAw = $clog2(TabDepth);

    // store read address select
    localparam logic [1:0] RdI = 2'd0;
    localparam logic [1:0] RdJ = 2'd1;
    localparam logic [1:0] RdBest = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DIST_RD,
        ST_DIST_WAIT,
        ST_DIST_CALC,
        ST_MED_INIT,
        ST_MED_RD,
        ST_MED_ACC,
        ST_MED_NEXT,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;        // store input item
        logic clr_set;     // start a new set
        logic ld_a;        // latch descriptor a from store read
        logic dist_wr;     // write distance pair
        logic med_clr;     // clear row median
        logic cand_ld;     // latch candidate, clear rank counters
        logic med_acc;     // accumulate one comparison
        logic med_eval;    // evaluate row candidate
        logic best_clr;
        logic best_upd;    // fold finished row into best
        logic out_capture;
    } ctrl_t;

    function automatic logic [DistW-1:0] popcnt64(input logic [63:0] v);
        logic [DistW-1:0] c;
        c = '0;
        for (int k = 0; k < 64; k++)
            c = c + DistW'(v[k]);
        return c;
    endfunction
endpackage

// ===== hdl/mhds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module mhds_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/mhds_datapath.sv =====
// Datapath: descriptor store, distance table, median counting and best tracking
module mhds_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mhds_pkg::ctrl_t            ctrl,
    input  logic [mhds_pkg::DescW-1:0] in_desc,
    input  logic [mhds_pkg::IdxW-1:0]  idx_i,
    input  logic [mhds_pkg::IdxW-1:0]  idx_j,
    input  logic [mhds_pkg::IdxW-1:0]  idx_k,
    input  logic [1:0]                 rsel,
    output logic [mhds_pkg::CntW-1:0]  count,
    output logic                       full,
    output logic [5:0]                 best_index,
    output logic [8:0]                 best_median,
    output logic [mhds_pkg::DescW-1:0] out_desc,
    output logic                       overflow
);
    import mhds_pkg::*;

    logic [CntW-1:0]  count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [DescW-1:0] desc_a_reg;
    logic [DescW-1:0] st_rdata;
    logic [IdxW-1:0]  st_waddr, st_raddr;
    logic [DistW-1:0] pair_dist;
    logic             tab_we;
    logic [TabAw-1:0] tab_waddr, tab_raddr, mirror_addr_reg;
    logic [DistW-1:0] tab_wdata, tab_rdata, tab_val;
    logic             diag_reg;
    logic [DistW-1:0] cand_reg;
    logic [CntW-1:0]  less_reg, le_reg;
    logic [CntW-1:0]  rank;
    logic             rank_hit;
    logic [DistW-1:0] row_val;
    logic [DistW-1:0] best_med_reg;
    logic [IdxW-1:0]  best_idx_reg;
    logic             have_best_reg;
    logic             med_found_reg;
    logic [DistW-1:0] row_med_reg;
    logic             dist_hi_reg;
    logic [DescW-1:0] out_desc_reg;

    assign full = (count_reg == CntW'(MaxDesc));
    assign count = count_reg;
    assign st_waddr = count_reg[IdxW-1:0];
    assign st_raddr = (rsel == RdI) ? idx_i : ((rsel == RdJ) ? idx_j : best_idx_reg);

    mhds_ram #(.Width(DescW), .Depth(MaxDesc)) u_store (
        .clk(clk), .we(ctrl.load && !full), .waddr(st_waddr), .wdata(in_desc),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    always_comb
    begin
        pair_dist = '0;
        for (int w = 0; w < 4; w++)
            pair_dist = pair_dist + popcnt64(desc_a_reg[w*64 +: 64] ^ st_rdata[w*64 +: 64]);
    end

    // second half of a symmetric pair is written on the following cycle
    assign tab_we = ctrl.dist_wr || dist_hi_reg;
    assign tab_waddr = dist_hi_reg ? mirror_addr_reg : {idx_i, idx_j};
    assign tab_wdata = ctrl.dist_wr ? pair_dist : cand_reg;
    assign tab_raddr = {idx_i, idx_k};

    mhds_ram #(.Width(DistW), .Depth(TabDepth)) u_table (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata)
    );

    // diagonal is never written; it reads as zero
    assign tab_val = diag_reg ? '0 : tab_rdata;

    assign rank = CntW'((count_reg - CntW'(1)) >> 1);
    assign rank_hit = (less_reg <= rank) && (rank < le_reg);
    assign row_val = (rank_hit && (!med_found_reg || cand_reg < row_med_reg)) ?
                     cand_reg : row_med_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next = ovf_reg;
        if (ctrl.clr_set)
        begin
            count_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg <= 1'b0;
            dist_hi_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            dist_hi_reg <= ctrl.dist_wr;
        end
    end

    // median by rank counting: candidate x = row[c] is the median when
    // less(x) <= rank < le(x)
    always_ff @(posedge clk)
    begin
        diag_reg <= (idx_k == idx_i);
        if (ctrl.ld_a)
            desc_a_reg <= st_rdata;
        if (ctrl.dist_wr)
        begin
            cand_reg <= pair_dist;
            mirror_addr_reg <= {idx_j, idx_i};
        end
        if (ctrl.med_clr)
        begin
            med_found_reg <= 1'b0;
            row_med_reg <= '0;
        end
        if (ctrl.cand_ld)
        begin
            cand_reg <= tab_val;
            less_reg <= '0;
            le_reg <= '0;
        end
        if (ctrl.med_acc)
        begin
            if (tab_val < cand_reg)
                less_reg <= less_reg + CntW'(1);
            if (tab_val <= cand_reg)
                le_reg <= le_reg + CntW'(1);
        end
        if (ctrl.med_eval)
        begin
            med_found_reg <= med_found_reg || rank_hit;
            row_med_reg <= row_val;
        end
        if (ctrl.best_clr)
            have_best_reg <= 1'b0;
        if (ctrl.best_upd && (!have_best_reg || row_val < best_med_reg))
        begin
            have_best_reg <= 1'b1;
            best_med_reg <= row_val;
            best_idx_reg <= idx_i;
        end
        if (ctrl.out_capture)
            out_desc_reg <= st_rdata;
    end

    assign best_index = 6'(best_idx_reg);
    assign best_median = 9'(best_med_reg);
    assign out_desc = out_desc_reg;
    assign overflow = ovf_reg;
endmodule

// ===== hdl/mhds_ctrl.sv =====
// Controller: sequences load, distance fill, median search and output
module mhds_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_last,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  logic [mhds_pkg::CntW-1:0] count,
    input  logic                      full,
    output mhds_pkg::ctrl_t           ctrl,
    output logic [mhds_pkg::IdxW-1:0] idx_i,
    output logic [mhds_pkg::IdxW-1:0] idx_j,
    output logic [mhds_pkg::IdxW-1:0] idx_k,
    output logic [1:0]                rsel
);
    import mhds_pkg::*;

    state_t state_reg, state_next;
    logic [IdxW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, c_reg, c_next;
    logic [IdxW-1:0] last_idx;
    logic [IdxW-1:0] n_idx;
    logic            hs;

    assign last_idx = IdxW'(count - CntW'(1));
    assign n_idx = IdxW'(count);
    assign hs = in_valid && in_ready;
    assign idx_i = i_reg;
    assign idx_j = j_reg;
    assign idx_k = k_reg;

    // Median search per row i: for each candidate c, ST_MED_INIT addresses
    // row[i][c], ST_MED_RD latches it, ST_MED_ACC streams the row one entry
    // a cycle (read runs one address ahead of the compare).
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        c_next = c_reg;
        case (state_reg)
            ST_LOAD:
                if (hs && in_last)
                begin
                    i_next = '0;
                    j_next = IdxW'(1);
                    c_next = '0;
                    k_next = '0;
                    // a set of one has no pairs
                    state_next = (count == '0) ? ST_MED_INIT : ST_DIST_RD;
                end
            ST_DIST_RD:
                state_next = ST_DIST_WAIT;
            ST_DIST_WAIT:
                state_next = ST_DIST_CALC;
            ST_DIST_CALC:
            begin
                state_next = ST_DIST_RD;
                if (j_reg == last_idx)
                begin
                    if (i_reg + IdxW'(1) == last_idx)
                    begin
                        i_next = '0;
                        state_next = ST_MED_INIT;
                    end
                    else
                    begin
                        i_next = i_reg + IdxW'(1);
                        j_next = i_reg + IdxW'(2);
                    end
                end
                else
                    j_next = j_reg + IdxW'(1);
                c_next = '0;
                k_next = '0;
            end
            ST_MED_INIT:
            begin
                k_next = '0;
                state_next = ST_MED_RD;
            end
            ST_MED_RD:
            begin
                k_next = IdxW'(1);
                state_next = ST_MED_ACC;
            end
            ST_MED_ACC:
            begin
                k_next = k_reg + IdxW'(1);
                if (k_reg == n_idx)
                    state_next = ST_MED_NEXT;
            end
            ST_MED_NEXT:
            begin
                if (c_reg == last_idx)
                begin
                    c_next = '0;
                    k_next = '0;
                    if (i_reg == last_idx)
                        state_next = ST_OUT_RD;
                    else
                    begin
                        i_next = i_reg + IdxW'(1);
                        state_next = ST_MED_INIT;
                    end
                end
                else
                begin
                    c_next = c_reg + IdxW'(1);
                    k_next = c_reg + IdxW'(1);
                    state_next = ST_MED_INIT;
                end
            end
            ST_OUT_RD:
                state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        rsel = RdI;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                ctrl.load = hs;
                ctrl.best_clr = 1'b1;
            end
            ST_DIST_RD:
                rsel = RdI;
            ST_DIST_WAIT:
            begin
                rsel = RdJ;
                ctrl.ld_a = 1'b1;
            end
            ST_DIST_CALC:
            begin
                rsel = RdJ;
                ctrl.dist_wr = 1'b1;
            end
            ST_MED_INIT:
                ctrl.med_clr = (c_reg == '0);
            ST_MED_RD:
                ctrl.cand_ld = 1'b1;
            ST_MED_ACC:
                ctrl.med_acc = 1'b1;
            ST_MED_NEXT:
            begin
                ctrl.med_eval = 1'b1;
                ctrl.best_upd = (c_reg == last_idx);
            end
            ST_OUT_RD:
                rsel = RdBest;
            ST_OUT_WAIT:
            begin
                rsel = RdBest;
                ctrl.out_capture = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                rsel = RdBest;
                ctrl.clr_set = out_ready;
            end
            default:
                ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            c_reg <= c_next;
        end
    end
endmodule

// ===== hdl/median_hamming_descriptor_select_core.sv =====
// Top level of the binary descriptor medoid selector
// Loads up to 64 descriptors at one item per cycle; the item with tlast
// closes the set and starts the evaluation. Pairwise distances are found
// one pair at a time (read, wait, calculate) through one store read
// port. The median of each row is found by rank counting over the
// distance table RAM, one candidate at a time, then the chosen
// descriptor is fetched from the store. One result item follows; new
// items are taken after it leaves.
module median_hamming_descriptor_select_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,   // word0, word1, word2, word3
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [271:0] m_axis_tdata,   // best_index, best_median, out_word0..3, zero pad
    output logic         m_axis_tuser    // overflow
);
    import mhds_pkg::*;

    ctrl_t           ctrl;
    logic [CntW-1:0] count;
    logic            full;
    logic [IdxW-1:0] idx_i, idx_j, idx_k;
    logic [1:0]      rsel;
    logic [5:0]      best_index;
    logic [8:0]      best_median;
    logic [DescW-1:0] out_desc;
    logic            overflow;

    mhds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .count(count), .full(full), .ctrl(ctrl), .idx_i(idx_i), .idx_j(idx_j),
        .idx_k(idx_k), .rsel(rsel)
    );

    mhds_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .in_desc(s_axis_tdata),
        .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k),
        .rsel(rsel), .count(count), .full(full), .best_index(best_index),
        .best_median(best_median), .out_desc(out_desc), .overflow(overflow)
    );

    assign m_axis_tdata = {1'b0, out_desc, best_median, best_index};
    assign m_axis_tuser = overflow;
endmodule

// ===== hdl/mhds_checker.sv =====
// Port checker for the descriptor medoid selector, bound to the top level
`include "median_hamming_descriptor_select_core_assert.svh"
module mhds_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [271:0] m_axis_tdata
);
    `MHDS_ASSERT_IMPL(a_no_in_while_out, m_axis_tvalid, !s_axis_tready)
    `MHDS_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `MHDS_ASSERT_NEXT(a_last_closes, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready)
    `MHDS_ASSERT_IMPL(a_median_range, m_axis_tvalid, m_axis_tdata[14:6] <= 9'd256)
endmodule

bind median_hamming_descriptor_select_core mhds_checker u_mhds_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the binary descriptor medoid selector
module testbench;
    import mhds_pkg::*;

    localparam int CycleLimit = 6000000;
    localparam int RandomItems = 1650;

    typedef struct {
        logic [IdxW-1:0]  index;
        logic [DistW-1:0] median;
        logic [DescW-1:0] desc;
        logic             overflow;
    } medoid_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;   // word0, word1, word2, word3
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [271:0] m_axis_tdata;   // best_index, best_median, out_word0..3, zero pad
    logic         m_axis_tuser;   // overflow

    medoid_t          medoid_q[$];
    logic [DescW-1:0] set_descs[$];
    bit               set_dropped;
    bit               quiet;
    int               errors;
    int               items_sent;
    int               sets_closed;
    int               results_seen;
    int               overflow_sets;
    longint           cycles = 0;

    median_hamming_descriptor_select_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, medoid_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);

    task automatic report_mismatch(input string what, input logic [255:0] got,
                                   input logic [255:0] want);
        errors++;
        $display("mismatch in result %0d, %s: got %h expected %h",
                 results_seen, what, got, want);
    endtask

    // predicted medoid of the closed set: smallest row median, first on ties
    function automatic medoid_t pick_medoid();
        medoid_t r;
        int      n;
        int      row[$];
        n = set_descs.size();
        r.index = '0;
        r.median = '0;
        r.desc = set_descs[0];
        r.overflow = set_dropped;
        for (int i = 0; i < n; i++)
        begin
            row.delete();
            for (int j = 0; j < n; j++)
                row = {row, $countones(set_descs[i] ^ set_descs[j])};
            row.sort();
            if (i == 0 || row[(n - 1) / 2] < r.median)
            begin
                r.median = DistW'(row[(n - 1) / 2]);
                r.index = IdxW'(i);
                r.desc = set_descs[i];
            end
        end
        return r;
    endfunction

    task automatic send_descriptor(input logic [DescW-1:0] d, input bit last);
        if (!quiet && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (set_descs.size() < MaxDesc)
            set_descs = {set_descs, d};
        else
            set_dropped = 1'b1;
        if (last)
        begin
            if (set_dropped)
                overflow_sets++;
            medoid_q = {medoid_q, pick_medoid()};
            sets_closed++;
            set_descs.delete();
            set_dropped = 1'b0;
        end
    endtask

    function automatic logic [DescW-1:0] rand_desc();
        logic [DescW-1:0] d;
        for (int k = 0; k < 8; k++)
            d[k*32 +: 32] = $urandom;
        return d;
    endfunction

    // sparse flips around a base: about one bit in eight
    function automatic logic [DescW-1:0] near(input logic [DescW-1:0] base);
        return base ^ (rand_desc() & rand_desc() & rand_desc());
    endfunction

    task automatic send_set(input int n, input int style);
        logic [DescW-1:0] base;
        logic [DescW-1:0] d;
        base = rand_desc();
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: d = rand_desc();
                1: d = near(base);
                default: d = ($urandom_range(3) == 0) ? base : near(base);
            endcase
            send_descriptor(d, i == n - 1);
        end
    endtask

    task automatic test_single_sets();
        send_descriptor('0, 1'b1);
        send_descriptor('1, 1'b1);
        send_descriptor(rand_desc(), 1'b1);
    endtask

    task automatic test_small_shapes();
        logic [DescW-1:0] a;
        a = rand_desc();
        // pair: both medians are zero, index 0 wins
        send_descriptor('0, 1'b0);
        send_descriptor('1, 1'b1);
        // identical descriptors tie on every row
        repeat (3) send_descriptor(a, 1'b0);
        send_descriptor(a, 1'b1);
        // outliers first so the medoid sits at a later index
        send_descriptor('1, 1'b0);
        send_descriptor(~a, 1'b0);
        send_descriptor(a, 1'b0);
        send_descriptor(near(a), 1'b0);
        send_descriptor(near(a), 1'b1);
    endtask

    task automatic test_full_capacity();
        send_set(MaxDesc, 1);
    endtask

    task automatic test_overflow();
        // two extra items dropped, the closing one among them
        logic [DescW-1:0] base;
        base = rand_desc();
        for (int i = 0; i < MaxDesc + 2; i++)
            send_descriptor(near(base), i == MaxDesc + 1);
    endtask

    task automatic test_random_sets();
        int start;
        start = items_sent;
        while (items_sent - start < RandomItems)
        begin
            quiet = (items_sent - start > 600 && items_sent - start < 800);
            if ($urandom_range(99) < 2)
                send_set($urandom_range(20, 30), $urandom_range(2));
            else
                send_set($urandom_range(1, 12), $urandom_range(2));
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_result
        medoid_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (medoid_q.size() == 0)
            begin
                errors++;
                $display("unexpected result item %h", m_axis_tdata);
            end
            else
            begin
                e = medoid_q.pop_front();
                if (m_axis_tdata[5:0] !== e.index)
                    report_mismatch("best_index", m_axis_tdata[5:0], e.index);
                if (m_axis_tdata[14:6] !== e.median)
                    report_mismatch("best_median", m_axis_tdata[14:6], e.median);
                for (int w = 0; w < 4; w++)
                    if (m_axis_tdata[15 + 64*w +: 64] !== e.desc[64*w +: 64])
                        report_mismatch($sformatf("out_word%0d", w),
                                        m_axis_tdata[15 + 64*w +: 64], e.desc[64*w +: 64]);
                if (m_axis_tuser !== e.overflow)
                    report_mismatch("overflow", m_axis_tuser, e.overflow);
            end
            results_seen++;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        quiet = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sets();
        test_small_shapes();
        test_full_capacity();
        test_overflow();
        test_random_sets();
        s_axis_tvalid <= 1'b0;

        while (medoid_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d descriptors in %0d sets, %0d with dropped items; %0d results checked",
                 items_sent, sets_closed, overflow_sets, results_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
